// ----- hdl/aps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and codes of the aging process scheduler.
// ----------------------------------------------------------------------------
package aps_pkg;

   localparam int OPCODE_BITS   = 2;
   localparam int IN_CHAN_BITS  = 16;
   localparam int OUT_SLOT_BITS = 3;

   localparam logic [OPCODE_BITS-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_WAIT   = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_WAKEUP = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_SPAWN  = 2'd3;

   typedef enum logic [1:0] {
      ST_DEAD = 2'd0,
      ST_RUN  = 2'd1,
      ST_WAIT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_WAIT,
      CMD_WAKE,
      CMD_PICK,
      CMD_CLAIM
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic init;
      logic spawn;
      logic found;
   } scan_ctl_type;

endpackage

// ----- hdl/aps_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_req_if
// Request channel: scheduler operation and wait channel.
// ----------------------------------------------------------------------------
interface aps_req_if;
   import aps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPCODE_BITS-1:0]  opcode;
   logic [IN_CHAN_BITS-1:0] channel;

   modport source (output valid, output opcode, output channel, input ready);
   modport sink   (input valid, input opcode, input channel, output ready);
endinterface

// ----- hdl/aps_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_rsp_if
// Response channel: current slot, switch flag, spawn result.
// ----------------------------------------------------------------------------
interface aps_rsp_if;
   import aps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OUT_SLOT_BITS-1:0] current;
   logic                     switched;
   logic [OUT_SLOT_BITS-1:0] new_slot;
   logic                     table_full;

   modport source (output valid, output current, output switched, output new_slot,
                   output table_full, input ready);
   modport sink   (input valid, input current, input switched, input new_slot,
                   input table_full, output ready);
endinterface

// ----- hdl/aging_process_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_process_scheduler_unit
// Aging task scheduler built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each slot lives in its own cell. A wakeup is applied to all cells at once
// in the apply state and goes straight on to the done state, which loads the
// output register. Tick, wait and spawn pass through launch, scan and commit
// first: a scan token goes down the cell chain, one cell per cycle, to find the
// oldest running slot (slot 0 seeds the search whatever its status, and a tie
// goes to the lower slot) or the first dead one, over the full chain.
// A new item is taken once the previous one is finished, even while its
// response still waits in the output register; the next item then stalls in
// its last cycle until that register is free.
// ----------------------------------------------------------------------------
module aging_process_scheduler_unit #(
   parameter int SLOTS        = 8,
   parameter int AGE_BITS     = 16,
   parameter int CHANNEL_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   aps_req_if.sink   req_ch,
   aps_rsp_if.source rsp_ch
);
   import aps_pkg::*;

   localparam int SLOT_BITS = (SLOTS > 2) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_LAUNCH,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type               state_ff;
   logic [OPCODE_BITS-1:0]  op_ff;
   logic [CHANNEL_BITS-1:0] chan_ff;
   logic [SLOT_BITS-1:0]    current_ff;
   logic [SLOT_BITS-1:0]    before_ff;
   logic [SLOT_BITS-1:0]    pick_ff;
   logic                    found_ff;

   logic                     rsp_valid_ff;
   logic [OUT_SLOT_BITS-1:0] rsp_current_ff;
   logic                     rsp_switched_ff;
   logic [OUT_SLOT_BITS-1:0] rsp_new_slot_ff;
   logic                     rsp_full_ff;

   cmd_type              cmd;
   logic [SLOT_BITS-1:0] cmd_slot;
   logic                 is_spawn;

   scan_ctl_type         scan_ctl  [SLOTS+1];
   logic [AGE_BITS-1:0]  scan_age  [SLOTS+1];
   logic [SLOT_BITS-1:0] scan_pick [SLOTS+1];

   assign is_spawn = (op_ff == OP_SPAWN);

   always_comb begin
      cmd      = CMD_NONE;
      cmd_slot = current_ff;
      if (state_ff == S_APPLY) begin
         unique case (op_ff)
            OP_TICK:   cmd = CMD_TICK;
            OP_WAIT:   cmd = CMD_WAIT;
            OP_WAKEUP: cmd = CMD_WAKE;
            default:   cmd = CMD_NONE;
         endcase
      end else if (state_ff == S_COMMIT) begin
         cmd_slot = pick_ff;
         if (!is_spawn) begin
            cmd = CMD_PICK;
         end else if (found_ff) begin
            cmd = CMD_CLAIM;
         end
      end
   end

   // inject the scan token at the head of the chain
   always_comb begin
      scan_ctl[0].valid = (state_ff == S_LAUNCH);
      scan_ctl[0].init  = 1'b1;
      scan_ctl[0].spawn = is_spawn;
      scan_ctl[0].found = 1'b0;
      scan_age[0]       = '0;
      scan_pick[0]      = '0;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      aps_cell #(
         .INDEX        (i),
         .SLOT_BITS    (SLOT_BITS),
         .AGE_BITS     (AGE_BITS),
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .cmd_slot      (cmd_slot),
         .cmd_chan      (chan_ff),
         .scan_ctl_in   (scan_ctl[i]),
         .scan_age_in   (scan_age[i]),
         .scan_pick_in  (scan_pick[i]),
         .scan_ctl_out  (scan_ctl[i+1]),
         .scan_age_out  (scan_age[i+1]),
         .scan_pick_out (scan_pick[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff     <= req_ch.opcode;
                  chan_ff   <= CHANNEL_BITS'(req_ch.channel);
                  before_ff <= current_ff;
                  state_ff  <= S_APPLY;
               end
            end
            S_APPLY: begin
               found_ff <= 1'b0;
               state_ff <= (op_ff == OP_WAKEUP) ? S_DONE : S_LAUNCH;
            end
            S_LAUNCH: state_ff <= S_SCAN;
            S_SCAN: begin
               if (scan_ctl[SLOTS].valid) begin
                  pick_ff  <= scan_pick[SLOTS];
                  found_ff <= scan_ctl[SLOTS].found;
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               if (!is_spawn) begin
                  current_ff <= pick_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_current_ff  <= OUT_SLOT_BITS'(current_ff);
                  rsp_switched_ff <= (current_ff != before_ff);
                  rsp_new_slot_ff <= (is_spawn && found_ff) ? OUT_SLOT_BITS'(pick_ff) : '0;
                  rsp_full_ff     <= is_spawn && !found_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.current    = rsp_current_ff;
   assign rsp_ch.switched   = rsp_switched_ff;
   assign rsp_ch.new_slot   = rsp_new_slot_ff;
   assign rsp_ch.table_full = rsp_full_ff;

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      scan_ctl[SLOTS].valid |-> state_ff == S_SCAN)
      else $error("scan token left the chain outside the scan phase");

   a_current_in_range: assert property (@(posedge clock) disable iff (reset)
      current_ff <= SLOT_BITS'(SLOTS - 1))
      else $error("current slot out of range");

   a_switch_not_spawn: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.switched |-> !rsp_ch.table_full && rsp_ch.new_slot == '0)
      else $error("switch reported together with a spawn result");

endmodule

// ----- hdl/aps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_cell
// One task slot: status, wait channel, age, and one stage of the scan chain.
// ----------------------------------------------------------------------------
module aps_cell #(
   parameter int INDEX        = 0,
   parameter int SLOT_BITS    = 3,
   parameter int AGE_BITS     = 16,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  aps_pkg::cmd_type         cmd,
   input  logic [SLOT_BITS-1:0]     cmd_slot,
   input  logic [CHANNEL_BITS-1:0]  cmd_chan,
   input  aps_pkg::scan_ctl_type    scan_ctl_in,
   input  logic [AGE_BITS-1:0]      scan_age_in,
   input  logic [SLOT_BITS-1:0]     scan_pick_in,
   output aps_pkg::scan_ctl_type    scan_ctl_out,
   output logic [AGE_BITS-1:0]      scan_age_out,
   output logic [SLOT_BITS-1:0]     scan_pick_out
);
   import aps_pkg::*;

   localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(INDEX);

   status_type              status_ff, status_in;
   logic [AGE_BITS-1:0]     age_ff, age_in, age_inc;
   logic [CHANNEL_BITS-1:0] chan_ff, chan_in;
   logic                    is_me;

   scan_ctl_type            sctl_ff, sctl_in;
   logic [AGE_BITS-1:0]     sage_ff, sage_in;
   logic [SLOT_BITS-1:0]    spick_ff, spick_in;

   assign is_me   = (cmd_slot == MY_SLOT);
   assign age_inc = (age_ff == '1) ? age_ff : age_ff + 1'b1;

   always_comb begin
      status_in = status_ff;
      age_in    = age_ff;
      chan_in   = chan_ff;
      case (cmd)
         CMD_TICK: age_in = age_inc;
         CMD_WAIT: begin
            if (is_me) begin
               status_in = ST_WAIT;
               chan_in   = cmd_chan;
            end else begin
               age_in = age_inc;
            end
         end
         CMD_WAKE: begin
            if (status_ff == ST_WAIT && chan_ff == cmd_chan) begin
               status_in = ST_RUN;
            end
         end
         CMD_PICK: begin
            if (is_me) begin
               age_in = '0;
            end
         end
         CMD_CLAIM: begin
            if (is_me) begin
               status_in = ST_RUN;
               age_in    = '0;
            end
         end
         default: ;
      endcase
   end

   // scan stage: spawn finds the first dead slot, a switch the oldest running one (seeded by cell 0)
   always_comb begin
      sctl_in      = scan_ctl_in;
      sctl_in.init = 1'b0;
      sage_in      = scan_age_in;
      spick_in     = scan_pick_in;
      if (scan_ctl_in.spawn) begin
         if (!scan_ctl_in.found && status_ff == ST_DEAD) begin
            sctl_in.found = 1'b1;
            spick_in      = MY_SLOT;
         end
      end else if (scan_ctl_in.init) begin
         sage_in  = age_ff;
         spick_in = MY_SLOT;
      end else if (status_ff == ST_RUN && scan_age_in < age_ff) begin
         sage_in  = age_ff;
         spick_in = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= (INDEX < 2) ? ST_RUN : ST_DEAD;
         age_ff        <= '0;
         sctl_ff.valid <= 1'b0;
      end else begin
         status_ff     <= status_in;
         age_ff        <= age_in;
         sctl_ff.valid <= sctl_in.valid;
      end
      chan_ff       <= chan_in;
      sctl_ff.init  <= sctl_in.init;
      sctl_ff.spawn <= sctl_in.spawn;
      sctl_ff.found <= sctl_in.found;
      sage_ff       <= sage_in;
      spick_ff      <= spick_in;
   end

   assign scan_ctl_out  = sctl_ff;
   assign scan_age_out  = sage_ff;
   assign scan_pick_out = spick_ff;

endmodule
